FILE: sv/heat_diffusion_stencil_step_defines.svh
// assertion macros for the heat diffusion stencil block
// expects clk and arst_n in the scope of the module that uses them
`ifndef HEAT_DIFFUSION_STENCIL_STEP_DEFINES_SVH
`define HEAT_DIFFUSION_STENCIL_STEP_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define HDS_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent must hold in the cycle after the antecedent
`define HDS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: sv/hds_pkg.sv
`timescale 1ns / 1ps
// shared constants, register codes and tag type for the heat diffusion stencil block
// no dependencies

package hds_pkg;

	localparam int GRID_MAX_DEF  = 256;
	localparam int FRAC_BITS_DEF = 16;
	localparam int GRID_MIN      = 20;

	localparam int GRID_W = 9;
	localparam int GAIN_W = 15;
	localparam int EPS_W  = 24;
	localparam int STEP_W = 13;
	localparam int SUM_W  = 36;
	localparam int APB_AW = 5;
	localparam int APB_DW = 32;

	localparam logic [GRID_W-1:0] GRID_SIZE_RST = 9'd64;
	localparam logic [GAIN_W-1:0] GAIN_RST      = 15'd3277;
	localparam logic [EPS_W-1:0]  EPS_RST       = 24'd66;
	localparam logic [STEP_W-1:0] MIN_STEPS_RST = 13'd100;
	localparam logic [STEP_W-1:0] MAX_STEPS_RST = 13'd5000;

	// fixed heat sources: interior position and integer value
	localparam int SRC_A_POS = 5;
	localparam int SRC_A_INT = 5;
	localparam int SRC_B_POS = 20;
	localparam int SRC_B_INT = 3;

	typedef enum logic [2:0] {
		REG_GRID_SIZE = 3'd0,
		REG_GAIN      = 3'd1,
		REG_EPSILON   = 3'd2,
		REG_MIN_STEPS = 3'd3,
		REG_MAX_STEPS = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic end_frame;
		logic clr_sum;
		logic src_a;
		logic src_b;
	} tag_t;

endpackage

FILE: sv/hds_row_store.sv
`timescale 1ns / 1ps
// one row store: single write port, two registered read ports, read-first
// no package dependencies

module hds_row_store #(
	parameter int DEPTH = 258,
	parameter int AW    = 9,
	parameter int DW    = 19
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [DW-1:0] wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr_a,
	input  logic [AW-1:0] rd_addr_b,
	output logic [DW-1:0] rd_data_a,
	output logic [DW-1:0] rd_data_b
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// reads see the contents from before a write at the same edge
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_a <= mem[rd_addr_a];
			rd_data_b <= mem[rd_addr_b];
		end
	end

endmodule

FILE: sv/hds_stencil.sv
`timescale 1ns / 1ps
// five-point update pipeline: laplacian, gain multiply, round and saturate
// depends on hds_pkg for the tag type and the gain width

module hds_stencil #(
	parameter int VW        = 19,
	parameter int FRAC_BITS = 16,
	parameter int CW        = 9
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [VW-1:0]             north,
	input  logic [VW-1:0]             south,
	input  logic [VW-1:0]             east,
	input  logic [VW-1:0]             west,
	input  logic [VW-1:0]             center,
	input  logic [CW-1:0]             row_in,
	input  logic [CW-1:0]             col_in,
	input  hds_pkg::tag_t             tag_in,
	input  logic [hds_pkg::GAIN_W-1:0] gain,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [VW-1:0]             value_out,
	output logic [CW-1:0]             row_out,
	output logic [CW-1:0]             col_out,
	output hds_pkg::tag_t             tag_out
);

	localparam int LW = VW + 3;
	localparam int PW = hds_pkg::GAIN_W + 1 + LW;
	localparam logic [PW-1:0] HALF = {{(PW-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};

	logic                 valid_s2, valid_s3, valid_s4;
	logic                 rdy2, rdy3, rdy4;
	logic signed [LW-1:0] lap_s2;
	logic [VW-1:0]        ctr_s2, ctr_s3;
	logic [CW-1:0]        row_s2, row_s3, row_s4;
	logic [CW-1:0]        col_s2, col_s3, col_s4;
	hds_pkg::tag_t        tag_s2, tag_s3, tag_s4;
	logic signed [PW-1:0] prod_s3;
	logic [VW-1:0]        val_s4;

	logic [LW-1:0]        lap_d;
	logic signed [PW-1:0] gain_x, lap_x, prod_d;
	logic signed [PW-1:0] q_d, r_d;
	logic [VW-1:0]        val_d;

	assign rdy4     = !valid_s4 || out_ready;
	assign rdy3     = !valid_s3 || rdy4;
	assign rdy2     = !valid_s2 || rdy3;
	assign in_ready = rdy2;

	// laplacian stays in range as a signed value of LW bits
	assign lap_d = LW'(north) + LW'(south) + LW'(east) + LW'(west) - (LW'(center) << 2);

	assign gain_x = {{(PW-hds_pkg::GAIN_W){1'b0}}, gain};
	assign lap_x  = {{(PW-LW){lap_s2[LW-1]}}, lap_s2};
	assign prod_d = gain_x * lap_x + $signed(HALF);

	// arithmetic shift gives round half up for both signs
	always_comb begin
		q_d = prod_s3 >>> FRAC_BITS;
		r_d = $signed({{(PW-VW){1'b0}}, ctr_s3}) + q_d;
		if (r_d[PW-1]) begin
			val_d = '0;
		end else if (r_d[PW-2:VW] != '0) begin
			val_d = '1;
		end else begin
			val_d = r_d[VW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (rdy2) valid_s2 <= in_valid;
			if (rdy3) valid_s3 <= valid_s2;
			if (rdy4) valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy2 && in_valid) begin
			lap_s2 <= $signed(lap_d);
			ctr_s2 <= center;
			row_s2 <= row_in;
			col_s2 <= col_in;
			tag_s2 <= tag_in;
		end
		if (rdy3 && valid_s2) begin
			prod_s3 <= prod_d;
			ctr_s3  <= ctr_s2;
			row_s3  <= row_s2;
			col_s3  <= col_s2;
			tag_s3  <= tag_s2;
		end
		if (rdy4 && valid_s3) begin
			val_s4 <= val_d;
			row_s4 <= row_s3;
			col_s4 <= col_s3;
			tag_s4 <= tag_s3;
		end
	end

	assign out_valid = valid_s4;
	assign value_out = val_s4;
	assign row_out   = row_s4;
	assign col_out   = col_s4;
	assign tag_out   = tag_s4;

endmodule

FILE: sv/hds_frame_acc.sv
`timescale 1ns / 1ps
// frame sum, source forcing, convergence and step-limit flags, output register
// depends on hds_pkg for widths, source constants and the tag type

module hds_frame_acc #(
	parameter int VW        = 19,
	parameter int FRAC_BITS = 16,
	parameter int CW        = 9
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [VW-1:0]             value_in,
	input  logic [CW-1:0]             row_in,
	input  logic [CW-1:0]             col_in,
	input  hds_pkg::tag_t             tag_in,
	input  logic [hds_pkg::EPS_W-1:0] epsilon,
	input  logic [hds_pkg::STEP_W-1:0] min_steps,
	input  logic [hds_pkg::STEP_W-1:0] max_steps,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [VW-1:0]             new_value,
	output logic [CW-1:0]             row_index,
	output logic [CW-1:0]             col_index,
	output logic                      end_of_frame,
	output logic [hds_pkg::SUM_W-1:0] frame_sum,
	output logic                      converged,
	output logic                      limit_reached
);

	localparam int SW = hds_pkg::SUM_W;
	localparam int TW = hds_pkg::STEP_W;
	localparam logic [VW-1:0] SRC_A_VAL = VW'(hds_pkg::SRC_A_INT) << FRAC_BITS;
	localparam logic [VW-1:0] SRC_B_VAL = VW'(hds_pkg::SRC_B_INT) << FRAC_BITS;

	logic          valid_s5, rdy5, out_load, out_valid_q;
	logic [SW-1:0] run_q, prev_q;
	logic [TW-1:0] step_q;
	logic [SW-1:0] sum_s5;
	logic [VW-1:0] val_s5;
	logic [CW-1:0] row_s5, col_s5;
	logic          end_s5;

	logic [SW-1:0] base_d, sum_sat, diff_d;
	logic [SW:0]   sum_x;
	logic [VW-1:0] forced_d;
	logic          conv_d, lim_d;

	assign out_load = !out_valid_q || out_ready;
	assign rdy5     = !valid_s5 || out_load;
	assign in_ready = rdy5;

	always_comb begin
		base_d  = tag_in.clr_sum ? '0 : run_q;
		sum_x   = (SW+1)'(base_d) + (SW+1)'(value_in);
		sum_sat = sum_x[SW] ? '1 : sum_x[SW-1:0];
		if (tag_in.src_b) begin
			forced_d = SRC_B_VAL;
		end else if (tag_in.src_a) begin
			forced_d = SRC_A_VAL;
		end else begin
			forced_d = value_in;
		end
	end

	always_comb begin
		diff_d = (sum_s5 >= prev_q) ? sum_s5 - prev_q : prev_q - sum_s5;
		conv_d = (diff_d < SW'(epsilon)) && (step_q > min_steps);
		lim_d  = ((TW+1)'(step_q) + (TW+1)'(1)) >= (TW+1)'(max_steps);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5    <= 1'b0;
			out_valid_q <= 1'b0;
			run_q       <= '0;
			prev_q      <= '0;
			step_q      <= '0;
		end else begin
			if (rdy5) valid_s5 <= in_valid;
			if (out_load) out_valid_q <= valid_s5;
			if (rdy5 && in_valid) begin
				run_q <= tag_in.end_frame ? '0 : sum_sat;
			end
			if (out_load && valid_s5 && end_s5) begin
				prev_q <= sum_s5;
				if (step_q != '1) step_q <= step_q + TW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy5 && in_valid) begin
			sum_s5 <= sum_sat;
			val_s5 <= forced_d;
			row_s5 <= row_in;
			col_s5 <= col_in;
			end_s5 <= tag_in.end_frame;
		end
		if (out_load && valid_s5) begin
			new_value     <= val_s5;
			row_index     <= row_s5;
			col_index     <= col_s5;
			end_of_frame  <= end_s5;
			frame_sum     <= end_s5 ? sum_s5 : '0;
			converged     <= end_s5 && conv_d;
			limit_reached <= end_s5 && lim_d;
		end
	end

	assign out_valid = out_valid_q;

endmodule

FILE: sv/heat_diffusion_stencil_step.sv
`timescale 1ns / 1ps
// channel   | direction | handshake          | payload
// ----------+-----------+--------------------+-------------------------------------------
// s_*       | in        | s_tvalid/s_tready  | cell_value in s_tdata, frame_start in s_tuser
// m_*       | out       | m_tvalid/m_tready  | result in m_tdata, end_of_frame on m_tlast
// apb       | in        | psel/penable       | register writes and reads, pready tied high
//
// one grid cell accepted per clock while s_tready is high; border cells give no result
// from an input transfer the result on m_* passes the position, laplacian, multiply, round,
// sum and flags registers; the gain multiply sets the cycle time
// row stores have no reset and no clearing pass; a pass fills them before use
// when m_tready is low the stages fill up and s_tready drops once the position stage
// cannot drain
// depends on hds_pkg, hds_row_store, hds_stencil, hds_frame_acc and the defines header

`include "heat_diffusion_stencil_step_defines.svh"

module heat_diffusion_stencil_step #(
	parameter int GRID_MAX  = hds_pkg::GRID_MAX_DEF,
	parameter int FRAC_BITS = hds_pkg::FRAC_BITS_DEF,
	localparam int VW  = 3 + FRAC_BITS,
	localparam int CW  = $clog2(GRID_MAX + 2),
	localparam int ITW = ((VW + 7) / 8) * 8,
	localparam int OD  = VW + 2 * CW + hds_pkg::SUM_W,
	localparam int OTW = ((OD + 7) / 8) * 8
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [ITW-1:0]            s_tdata,   // cell_value
	input  logic                      s_tuser,   // frame_start
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [OTW-1:0]            m_tdata,   // new_value, row_index, col_index, frame_sum
	output logic                      m_tlast,
	output logic [1:0]                m_tuser,   // converged, limit_reached
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [hds_pkg::APB_AW-1:0] paddr,
	input  logic [hds_pkg::APB_DW-1:0] pwdata,
	output logic [hds_pkg::APB_DW-1:0] prdata,
	output logic                      pready
);

	localparam int DEPTH = GRID_MAX + 2;
	localparam int XW    = (CW > hds_pkg::GRID_W ? CW : hds_pkg::GRID_W) + 2;

	// configuration registers
	logic [hds_pkg::GRID_W-1:0] grid_size_q;
	logic [hds_pkg::GAIN_W-1:0] gain_q;
	logic [hds_pkg::EPS_W-1:0]  eps_q;
	logic [hds_pkg::STEP_W-1:0] min_steps_q;
	logic [hds_pkg::STEP_W-1:0] max_steps_q;

	// position
	logic [CW-1:0] row_q, col_q;
	logic [XW-1:0] gsel, side, rr, cc, rn, cn;
	logic          interior, frame_end, src_a, src_b;
	logic [CW-1:0] c_cur, c_east, c_west, ri_cur;
	logic          accept;

	// position stage
	logic          valid_s1, int_s1, fs_s1, end_s1, srca_s1, srcb_s1;
	logic [VW-1:0] u_s1;
	logic [CW-1:0] c_s1, ri_s1;
	logic          s1_leave, ready_s1, up_wr;
	logic          clr_pend_q;
	logic          fwd_n_q, fwd_w_q;
	logic [VW-1:0] fwd_d_q;

	logic [VW-1:0] mid_c, mid_e, up_n, up_w;
	logic [VW-1:0] north, west;

	logic          st_in_ready, st_valid, st_ready;
	logic [VW-1:0] st_value;
	logic [CW-1:0] st_row, st_col;
	hds_pkg::tag_t tag_s1, st_tag;

	logic [VW-1:0]              new_value;
	logic [CW-1:0]              row_index, col_index;
	logic [hds_pkg::SUM_W-1:0]  frame_sum;
	logic                       converged, limit_reached;

	// register interface
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_size_q <= hds_pkg::GRID_SIZE_RST;
			gain_q      <= hds_pkg::GAIN_RST;
			eps_q       <= hds_pkg::EPS_RST;
			min_steps_q <= hds_pkg::MIN_STEPS_RST;
			max_steps_q <= hds_pkg::MAX_STEPS_RST;
		end else if (psel && penable && pwrite && pready) begin
			case (paddr[4:2])
				hds_pkg::REG_GRID_SIZE: grid_size_q <= pwdata[hds_pkg::GRID_W-1:0];
				hds_pkg::REG_GAIN:      gain_q      <= pwdata[hds_pkg::GAIN_W-1:0];
				hds_pkg::REG_EPSILON:   eps_q       <= pwdata[hds_pkg::EPS_W-1:0];
				hds_pkg::REG_MIN_STEPS: min_steps_q <= pwdata[hds_pkg::STEP_W-1:0];
				hds_pkg::REG_MAX_STEPS: max_steps_q <= pwdata[hds_pkg::STEP_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:2])
			hds_pkg::REG_GRID_SIZE: prdata = hds_pkg::APB_DW'(grid_size_q);
			hds_pkg::REG_GAIN:      prdata = hds_pkg::APB_DW'(gain_q);
			hds_pkg::REG_EPSILON:   prdata = hds_pkg::APB_DW'(eps_q);
			hds_pkg::REG_MIN_STEPS: prdata = hds_pkg::APB_DW'(min_steps_q);
			hds_pkg::REG_MAX_STEPS: prdata = hds_pkg::APB_DW'(max_steps_q);
			default:                prdata = '0;
		endcase
	end

	// position of the incoming cell, padded side from the clamped grid size
	always_comb begin
		gsel = XW'(grid_size_q);
		if (gsel < XW'(hds_pkg::GRID_MIN)) begin
			gsel = XW'(hds_pkg::GRID_MIN);
		end else if (gsel > XW'(GRID_MAX)) begin
			gsel = XW'(GRID_MAX);
		end
		side = gsel + XW'(2);

		rr = XW'(row_q);
		cc = XW'(col_q);
		if (s_tuser) begin
			rr = '0;
			cc = '0;
		end
		// grid may have shrunk under the counters
		if (cc > side - XW'(1)) begin
			cc = '0;
			rr = rr + XW'(1);
		end
		if (rr > side - XW'(1)) begin
			rr = '0;
		end

		cn = cc + XW'(1);
		rn = rr;
		if (cn >= side) begin
			cn = '0;
			rn = rr + XW'(1);
			if (rn >= side) begin
				rn = '0;
			end
		end

		interior  = (rr >= XW'(2)) && (cc >= XW'(1)) && (cc <= side - XW'(2));
		frame_end = (rr == side - XW'(1)) && (cc == side - XW'(2));
		src_a     = (rr == XW'(hds_pkg::SRC_A_POS + 1)) && (cc == XW'(hds_pkg::SRC_A_POS));
		src_b     = (rr == XW'(hds_pkg::SRC_B_POS + 1)) && (cc == XW'(hds_pkg::SRC_B_POS));
	end

	assign c_cur  = cc[CW-1:0];
	assign c_east = c_cur + CW'(1);
	assign c_west = c_cur - CW'(1);
	assign ri_cur = CW'(rr - XW'(1));

	// border cells leave the position stage without entering the stencil
	assign s1_leave = valid_s1 && (!int_s1 || st_in_ready);
	assign ready_s1 = !valid_s1 || s1_leave;
	assign s_tready = ready_s1;
	assign accept   = s_tvalid && s_tready;
	assign up_wr    = s1_leave;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q      <= '0;
			col_q      <= '0;
			valid_s1   <= 1'b0;
			clr_pend_q <= 1'b0;
			fwd_n_q    <= 1'b0;
			fwd_w_q    <= 1'b0;
		end else begin
			if (ready_s1) valid_s1 <= s_tvalid;
			if (accept) begin
				row_q   <= rn[CW-1:0];
				col_q   <= cn[CW-1:0];
				// upper store entry written at this same edge
				fwd_n_q <= up_wr && (c_s1 == c_cur);
				fwd_w_q <= up_wr && (c_s1 == c_west);
			end
			// a frame start clears the sum ahead of the next interior cell
			if (s1_leave) begin
				clr_pend_q <= int_s1 ? 1'b0 : (clr_pend_q || fs_s1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			u_s1    <= s_tdata[VW-1:0];
			c_s1    <= c_cur;
			ri_s1   <= ri_cur;
			int_s1  <= interior;
			fs_s1   <= s_tuser;
			end_s1  <= frame_end;
			srca_s1 <= src_a;
			srcb_s1 <= src_b;
			fwd_d_q <= mid_c;
		end
	end

	hds_row_store #(
		.DEPTH (DEPTH),
		.AW    (CW),
		.DW    (VW)
	) u_mid_store (
		.clk       (clk),
		.wr_en     (accept),
		.wr_addr   (c_cur),
		.wr_data   (s_tdata[VW-1:0]),
		.rd_en     (accept),
		.rd_addr_a (c_cur),
		.rd_addr_b (c_east),
		.rd_data_a (mid_c),
		.rd_data_b (mid_e)
	);

	hds_row_store #(
		.DEPTH (DEPTH),
		.AW    (CW),
		.DW    (VW)
	) u_up_store (
		.clk       (clk),
		.wr_en     (up_wr),
		.wr_addr   (c_s1),
		.wr_data   (mid_c),
		.rd_en     (accept),
		.rd_addr_a (c_cur),
		.rd_addr_b (c_west),
		.rd_data_a (up_n),
		.rd_data_b (up_w)
	);

	assign north = fwd_n_q ? fwd_d_q : up_n;
	assign west  = fwd_w_q ? fwd_d_q : up_w;

	always_comb begin
		tag_s1.end_frame = end_s1;
		tag_s1.clr_sum   = clr_pend_q || fs_s1;
		tag_s1.src_a     = srca_s1;
		tag_s1.src_b     = srcb_s1;
	end

	hds_stencil #(
		.VW        (VW),
		.FRAC_BITS (FRAC_BITS),
		.CW        (CW)
	) u_stencil (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s1 && int_s1),
		.in_ready  (st_in_ready),
		.north     (north),
		.south     (u_s1),
		.east      (mid_e),
		.west      (west),
		.center    (mid_c),
		.row_in    (ri_s1),
		.col_in    (c_s1),
		.tag_in    (tag_s1),
		.gain      (gain_q),
		.out_valid (st_valid),
		.out_ready (st_ready),
		.value_out (st_value),
		.row_out   (st_row),
		.col_out   (st_col),
		.tag_out   (st_tag)
	);

	hds_frame_acc #(
		.VW        (VW),
		.FRAC_BITS (FRAC_BITS),
		.CW        (CW)
	) u_frame_acc (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (st_valid),
		.in_ready      (st_ready),
		.value_in      (st_value),
		.row_in        (st_row),
		.col_in        (st_col),
		.tag_in        (st_tag),
		.epsilon       (eps_q),
		.min_steps     (min_steps_q),
		.max_steps     (max_steps_q),
		.out_valid     (m_tvalid),
		.out_ready     (m_tready),
		.new_value     (new_value),
		.row_index     (row_index),
		.col_index     (col_index),
		.end_of_frame  (m_tlast),
		.frame_sum     (frame_sum),
		.converged     (converged),
		.limit_reached (limit_reached)
	);

	assign m_tdata = OTW'({frame_sum, col_index, row_index, new_value});
	assign m_tuser = {limit_reached, converged};

	`HDS_ASSERT_SAME(a_flags_only_at_end, m_tvalid && !m_tlast,
		m_tuser == 2'b00 && frame_sum == '0, "status flags or sum outside frame end")
	`HDS_ASSERT_NEXT(a_west_forward, up_wr && accept && (c_s1 == c_west),
		fwd_w_q, "west tap missed the pending upper store write")
	`HDS_ASSERT_NEXT(a_clear_consumed, s1_leave && int_s1,
		!clr_pend_q, "sum clear still pending after an interior cell")
	`HDS_ASSERT_SAME(a_ready_when_empty, !valid_s1,
		s_tready, "input stalled with an empty position stage")

endmodule
